FILE: rtl/core/frt_pkg.sv
// shared types and constants for the fragment reassembly table
// no dependencies; used by every module under rtl/core
package frt_pkg;

    localparam int SLOTS_DEF = 4;

    localparam int MAC_W   = 48;
    localparam int TYPE_W  = 8;
    localparam int FIDX_W  = 8;
    localparam int LEN_W   = 8;
    localparam int BYTES_W = 16;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 2;

    localparam logic OP_FRAG    = 1'b0;
    localparam logic OP_DELIVER = 1'b1;

    typedef enum logic [1:0] {
        SL_FREE = 2'd0,
        SL_BUSY = 2'd1,
        SL_WAIT = 2'd2
    } t_slot_st;

    typedef enum logic [STAT_W-1:0] {
        RES_DROP      = 3'd0,
        RES_STORED    = 3'd1,
        RES_COMPLETE  = 3'd2,
        RES_DELIVERED = 3'd3,
        RES_EMPTY     = 3'd4
    } t_res_code;

    // one slot entry as read from the table
    typedef struct packed {
        t_slot_st                 st;
        logic [MAC_W-1:0]         peer;
        logic [TYPE_W-1:0]        ty;
        logic [BYTES_W-1:0]       bytes;
    } t_slot_rd;

    // write to the table, slot index travels separately
    typedef struct packed {
        logic                     en;
        t_slot_st                 st;
        logic [MAC_W-1:0]         peer;
        logic [TYPE_W-1:0]        ty;
        logic [BYTES_W-1:0]       bytes;
    } t_slot_wr;

    // verdict of the shared compare/add unit for one slot
    typedef struct packed {
        logic                     hit;
        logic                     complete;
        logic [BYTES_W-1:0]       new_bytes;
    } t_alu_res;

endpackage

FILE: rtl/core/frt_slot_table.sv
// slot table storage: status, sender address, type and byte count per slot
// depends on frt_pkg
module frt_slot_table #(
    parameter int SLOTS = frt_pkg::SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IW-1:0]      i_rd_idx,
    output frt_pkg::t_slot_rd  o_rd,
    input  logic [IW-1:0]      i_wr_idx,
    input  frt_pkg::t_slot_wr  i_wr
);

    frt_pkg::t_slot_st                  r_st    [SLOTS];
    logic [frt_pkg::MAC_W-1:0]          r_peer  [SLOTS];
    logic [frt_pkg::TYPE_W-1:0]         r_type  [SLOTS];
    logic [frt_pkg::BYTES_W-1:0]        r_bytes [SLOTS];

    // status needs reset; a free slot's other fields are never used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= frt_pkg::SL_FREE;
            end
        end else if (i_wr.en) begin
            r_st[i_wr_idx] <= i_wr.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_peer[i_wr_idx]  <= i_wr.peer;
            r_type[i_wr_idx]  <= i_wr.ty;
            r_bytes[i_wr_idx] <= i_wr.bytes;
        end
    end

    always_comb begin
        o_rd.st    = r_st[i_rd_idx];
        o_rd.peer  = r_peer[i_rd_idx];
        o_rd.ty    = r_type[i_rd_idx];
        o_rd.bytes = r_bytes[i_rd_idx];
    end

endmodule

FILE: rtl/core/frt_slot_alu.sv
// shared slot unit: match test for one slot plus saturating byte add
// depends on frt_pkg
module frt_slot_alu (
    input  logic                        i_opcode,
    input  frt_pkg::t_slot_rd           i_rd,
    input  logic [frt_pkg::MAC_W-1:0]   i_mac,
    input  logic [frt_pkg::FIDX_W-1:0]  i_findex,
    input  logic [frt_pkg::FIDX_W-1:0]  i_ftotal,
    input  logic [frt_pkg::LEN_W-1:0]   i_len,
    output frt_pkg::t_alu_res           o_res
);

    logic [frt_pkg::BYTES_W:0] sum;
    logic                      first;

    assign first = (i_findex == '0);
    assign sum   = {1'b0, i_rd.bytes} + (frt_pkg::BYTES_W + 1)'(i_len);

    always_comb begin
        if (i_opcode == frt_pkg::OP_DELIVER) begin
            o_res.hit = (i_rd.st == frt_pkg::SL_WAIT);
        end else if (first) begin
            o_res.hit = (i_rd.st == frt_pkg::SL_FREE);
        end else begin
            o_res.hit = (i_rd.st == frt_pkg::SL_BUSY) && (i_rd.peer == i_mac);
        end

        o_res.complete = (i_ftotal != '0) && (i_findex == (i_ftotal - 8'd1));

        // a free slot always starts from an empty count
        if (first) begin
            o_res.new_bytes = frt_pkg::BYTES_W'(i_len);
        end else if (sum[frt_pkg::BYTES_W]) begin
            o_res.new_bytes = '1;
        end else begin
            o_res.new_bytes = sum[frt_pkg::BYTES_W-1:0];
        end
    end

endmodule

FILE: rtl/core/fragment_reassembly_table.sv
// fragment reassembly table: item accepted on start && !busy, then one slot
// per cycle goes through the shared match unit, lowest slot first.
// the result strobe is registered; the scan stops at the first hit
// a new item is accepted only after the slot scan has ended and busy drops
// reset: synchronous active low, all slots free; results cannot be stalled
module fragment_reassembly_table #(
    parameter int SLOTS = frt_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [frt_pkg::MAC_W-1:0]   i_peer_mac,
    input  logic [frt_pkg::TYPE_W-1:0]  i_pkt_type,
    input  logic [frt_pkg::FIDX_W-1:0]  i_fragment_index,
    input  logic [frt_pkg::FIDX_W-1:0]  i_fragment_total,
    input  logic [frt_pkg::LEN_W-1:0]   i_payload_len,
    output logic                        o_valid,
    output logic [frt_pkg::STAT_W-1:0]  o_status,
    output logic [frt_pkg::SLOT_W-1:0]  o_slot,
    output logic [frt_pkg::TYPE_W-1:0]  o_msg_type,
    output logic [frt_pkg::BYTES_W-1:0] o_msg_bytes
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_valid, n_valid;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_opcode, n_opcode;
    logic [frt_pkg::MAC_W-1:0]     r_mac, n_mac;
    logic [frt_pkg::TYPE_W-1:0]    r_type, n_type;
    logic [frt_pkg::FIDX_W-1:0]    r_findex, n_findex;
    logic [frt_pkg::FIDX_W-1:0]    r_ftotal, n_ftotal;
    logic [frt_pkg::LEN_W-1:0]     r_len, n_len;
    frt_pkg::t_res_code            r_status, n_status;
    logic [frt_pkg::SLOT_W-1:0]    r_slot, n_slot;
    logic [frt_pkg::TYPE_W-1:0]    r_msg_type, n_msg_type;
    logic [frt_pkg::BYTES_W-1:0]   r_msg_bytes, n_msg_bytes;

    frt_pkg::t_slot_rd             rd;
    frt_pkg::t_slot_wr             wr;
    frt_pkg::t_alu_res             alu;

    frt_slot_table #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (rd),
        .i_wr_idx (r_idx),
        .i_wr     (wr)
    );

    frt_slot_alu u_alu (
        .i_opcode (r_opcode),
        .i_rd     (rd),
        .i_mac    (r_mac),
        .i_findex (r_findex),
        .i_ftotal (r_ftotal),
        .i_len    (r_len),
        .o_res    (alu)
    );

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_idx       = r_idx;
        n_opcode    = r_opcode;
        n_mac       = r_mac;
        n_type      = r_type;
        n_findex    = r_findex;
        n_ftotal    = r_ftotal;
        n_len       = r_len;
        n_status    = r_status;
        n_slot      = r_slot;
        n_msg_type  = r_msg_type;
        n_msg_bytes = r_msg_bytes;
        wr.en       = 1'b0;
        wr.st       = frt_pkg::SL_FREE;
        wr.peer     = r_mac;
        wr.ty       = r_type;
        wr.bytes    = alu.new_bytes;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_opcode = i_opcode;
                    n_mac    = i_peer_mac;
                    n_type   = i_pkt_type;
                    n_findex = i_fragment_index;
                    n_ftotal = i_fragment_total;
                    n_len    = i_payload_len;
                    n_idx    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (alu.hit) begin
                    wr.en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    n_slot  = frt_pkg::SLOT_W'(r_idx);
                    if (r_opcode == frt_pkg::OP_DELIVER) begin
                        wr.st       = frt_pkg::SL_FREE;
                        n_status    = frt_pkg::RES_DELIVERED;
                        n_msg_type  = rd.ty;
                        n_msg_bytes = rd.bytes;
                    end else begin
                        wr.st       = alu.complete ? frt_pkg::SL_WAIT : frt_pkg::SL_BUSY;
                        n_status    = alu.complete ? frt_pkg::RES_COMPLETE
                                                   : frt_pkg::RES_STORED;
                        n_msg_type  = r_type;
                        n_msg_bytes = alu.new_bytes;
                    end
                end else if (r_idx == LAST) begin
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = (r_opcode == frt_pkg::OP_DELIVER) ? frt_pkg::RES_EMPTY
                                                                    : frt_pkg::RES_DROP;
                    n_slot      = '0;
                    n_msg_type  = '0;
                    n_msg_bytes = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_idx       <= n_idx;
        r_opcode    <= n_opcode;
        r_mac       <= n_mac;
        r_type      <= n_type;
        r_findex    <= n_findex;
        r_ftotal    <= n_ftotal;
        r_len       <= n_len;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_msg_type  <= n_msg_type;
        r_msg_bytes <= n_msg_bytes;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_msg_type  = r_msg_type;
    assign o_msg_bytes = r_msg_bytes;

endmodule

FILE: tb/sv/tb_top.sv
// testbench for fragment_reassembly_table: directed and random fragment/deliver items,
// checked against a slot-table predictor held in a small scoreboard class
// depends on frt_pkg and the fragment_reassembly_table rtl
`timescale 1ns / 100ps

module tb_top;
    import frt_pkg::*;

    localparam int SLOTS     = SLOTS_DEF;
    localparam int CYC_LIMIT = 200000;

    typedef struct {
        logic               op;
        logic [MAC_W-1:0]   mac;
        logic [TYPE_W-1:0]  ty;
        logic [FIDX_W-1:0]  idx;
        logic [FIDX_W-1:0]  total;
        logic [LEN_W-1:0]   len;
    } frag_item_t;

    typedef struct {
        t_res_code          status;
        logic [SLOT_W-1:0]  slot;
        logic [TYPE_W-1:0]  ty;
        logic [BYTES_W-1:0] bytes;
    } frag_result_t;

    class frag_table_sb;
        t_slot_st           slot_st[SLOTS];
        logic [MAC_W-1:0]   slot_mac[SLOTS];
        logic [TYPE_W-1:0]  slot_ty[SLOTS];
        logic [BYTES_W-1:0] slot_cnt[SLOTS];
        frag_result_t       due_q[$];
        int                 mismatches;

        function new();
            foreach (slot_st[i]) begin
                slot_st[i]  = SL_FREE;
                slot_mac[i] = '0;
                slot_ty[i]  = '0;
                slot_cnt[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function void note_item(frag_item_t it);
            frag_result_t     r;
            int               hit;
            logic [BYTES_W:0] sum;
            r.status = RES_DROP;
            r.slot   = '0;
            r.ty     = '0;
            r.bytes  = '0;
            hit      = -1;
            if (it.op == OP_DELIVER) begin
                r.status = RES_EMPTY;
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_st[i] == SL_WAIT) hit = i;
                if (hit >= 0) begin
                    r.status      = RES_DELIVERED;
                    r.slot        = hit[SLOT_W-1:0];
                    r.ty          = slot_ty[hit];
                    r.bytes       = slot_cnt[hit];
                    slot_st[hit]  = SL_FREE;
                    slot_ty[hit]  = '0;
                    slot_cnt[hit] = '0;
                end
            end else begin
                // index 0 opens a free slot, later fragments follow the sender
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0) begin
                        if (it.idx == '0) begin
                            if (slot_st[i] == SL_FREE) hit = i;
                        end else if (slot_st[i] == SL_BUSY && slot_mac[i] == it.mac) begin
                            hit = i;
                        end
                    end
                end
                if (hit >= 0) begin
                    sum           = {1'b0, slot_cnt[hit]} + (BYTES_W + 1)'(it.len);
                    slot_st[hit]  = SL_BUSY;
                    slot_mac[hit] = it.mac;
                    slot_ty[hit]  = it.ty;
                    slot_cnt[hit] = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    r.status      = RES_STORED;
                    if (it.total != '0 && it.idx == it.total - 8'd1) begin
                        slot_st[hit] = SL_WAIT;
                        r.status     = RES_COMPLETE;
                    end
                    r.slot  = hit[SLOT_W-1:0];
                    r.ty    = slot_ty[hit];
                    r.bytes = slot_cnt[hit];
                end
            end
            due_q.push_back(r);
        endfunction

        function void check_result(frag_result_t got);
            frag_result_t want;
            if (due_q.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d",
                       got.status, got.slot);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.slot != want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.ty != want.ty) begin
                $error("msg_type: expected %0d, actual %0d", want.ty, got.ty);
                mismatches++;
            end
            if (got.bytes != want.bytes) begin
                $error("msg_bytes: expected %0d, actual %0d", want.bytes, got.bytes);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               cmd_start;
    logic               dut_busy;
    logic               cmd_op;
    logic [MAC_W-1:0]   cmd_mac;
    logic [TYPE_W-1:0]  cmd_type;
    logic [FIDX_W-1:0]  cmd_idx;
    logic [FIDX_W-1:0]  cmd_total;
    logic [LEN_W-1:0]   cmd_len;
    logic               res_valid;
    logic [STAT_W-1:0]  res_status;
    logic [SLOT_W-1:0]  res_slot;
    logic [TYPE_W-1:0]  res_type;
    logic [BYTES_W-1:0] res_bytes;

    frag_table_sb       sb;
    int                 cycle_cnt = 0;
    int                 sent_cnt  = 0;
    bit                 no_idle   = 0;
    logic [MAC_W-1:0]   mac_pool[6];

    fragment_reassembly_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (cmd_start),
        .busy             (dut_busy),
        .i_opcode         (cmd_op),
        .i_peer_mac       (cmd_mac),
        .i_pkt_type       (cmd_type),
        .i_fragment_index (cmd_idx),
        .i_fragment_total (cmd_total),
        .i_payload_len    (cmd_len),
        .o_valid          (res_valid),
        .o_status         (res_status),
        .o_slot           (res_slot),
        .o_msg_type       (res_type),
        .o_msg_bytes      (res_bytes)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYC_LIMIT) begin
            $display("fragment_reassembly_table verification failed");
            $finish;
        end
    end

    // accepted items and results, sampled before this edge's updates land
    always @(posedge i_clk) begin
        frag_item_t   it;
        frag_result_t got;
        if (i_rst_n) begin
            if (cmd_start && !dut_busy) begin
                it.op    = cmd_op;
                it.mac   = cmd_mac;
                it.ty    = cmd_type;
                it.idx   = cmd_idx;
                it.total = cmd_total;
                it.len   = cmd_len;
                sb.note_item(it);
            end
            if (res_valid) begin
                got.status = t_res_code'(res_status);
                got.slot   = res_slot;
                got.ty     = res_type;
                got.bytes  = res_bytes;
                sb.check_result(got);
            end
        end
    end

    function automatic frag_item_t frag(logic [MAC_W-1:0] mac, int ty, int idx, int tot,
                                        int len);
        frag_item_t f;
        f.op    = OP_FRAG;
        f.mac   = mac;
        f.ty    = ty[TYPE_W-1:0];
        f.idx   = idx[FIDX_W-1:0];
        f.total = tot[FIDX_W-1:0];
        f.len   = len[LEN_W-1:0];
        return f;
    endfunction

    // the other fields are ignored on delivery, so they carry noise
    function automatic frag_item_t deliver_req();
        frag_item_t f;
        f    = frag(MAC_W'({$urandom, $urandom}), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 250));
        f.op = OP_DELIVER;
        return f;
    endfunction

    task automatic send_item(frag_item_t it);
        int gap;
        sent_cnt++;
        if (sent_cnt % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            cmd_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_op    <= it.op;
        cmd_mac   <= it.mac;
        cmd_type  <= it.ty;
        cmd_idx   <= it.idx;
        cmd_total <= it.total;
        cmd_len   <= it.len;
        cmd_start <= 1'b1;
        do @(posedge i_clk); while (dut_busy);
    endtask

    // hold off until every expected result is back, then let the scan run out
    task automatic settle();
        cmd_start <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    initial begin
        logic [MAC_W-1:0] open_mac[3];
        int               open_tot[3];
        int               open_next[3];
        bit               open_live[3];
        frag_item_t       it;
        int               sel;
        int               k;

        sb        = new();
        i_rst_n   = 1'b0;
        cmd_start = 1'b0;
        cmd_op    = OP_FRAG;
        cmd_mac   = '0;
        cmd_type  = '0;
        cmd_idx   = '0;
        cmd_total = '0;
        cmd_len   = '0;
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        mac_pool[2] = MAC_W'({$urandom, $urandom});
        mac_pool[3] = MAC_W'({$urandom, $urandom});
        mac_pool[4] = 48'h5555_5555_5555;
        mac_pool[5] = 48'hAAAA_AAAA_AAAA;
        foreach (open_live[i]) open_live[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, drop, tot of one, tot of zero, out of order,
        // full table, same sender reopening, index 255, delivery order
        send_item(deliver_req());
        send_item(frag(mac_pool[1], 8'h11, 3, 4, 10));
        send_item(frag(mac_pool[1], 8'hFF, 0, 1, 250));
        send_item(frag(mac_pool[0], 8'h00, 0, 0, 0));
        send_item(frag(mac_pool[2], 8'h5A, 0, 3, 1));
        send_item(frag(mac_pool[2], 8'hA5, 7, 3, 2));
        send_item(frag(mac_pool[2], 8'h3C, 2, 3, 128));
        send_item(frag(mac_pool[3], 8'h01, 0, 255, 127));
        send_item(frag(mac_pool[1], 8'h02, 0, 2, 5));
        send_item(deliver_req());
        send_item(frag(mac_pool[3], 8'h80, 0, 2, 64));
        send_item(frag(mac_pool[3], 8'h7F, 1, 2, 65));
        send_item(frag(mac_pool[3], 8'hC3, 255, 255, 200));
        send_item(frag(mac_pool[3], 8'h0F, 254, 255, 250));
        send_item(frag(mac_pool[0], 8'hF0, 255, 0, 85));
        send_item(frag(mac_pool[0], 8'h99, 1, 2, 170));
        repeat (5) send_item(deliver_req());
        settle();

        // byte count saturation on one long message with total of zero
        send_item(frag(mac_pool[1], 8'h42, 0, 0, 250));
        for (int j = 0; j < 270; j++)
            send_item(frag(mac_pool[1], $urandom_range(0, 255), 1 + (j % 200), 0, 250));
        send_item(frag(mac_pool[1], 8'h24, 9, 10, 250));
        send_item(deliver_req());
        settle();

        // random: mostly interleaved well-formed messages, some broken ones and noise
        for (int n = 0; n < 750; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
                send_item(deliver_req());
            end else if (sel < 85) begin
                k = $urandom_range(0, 2);
                if (!open_live[k]) begin
                    open_mac[k]  = mac_pool[$urandom_range(0, 5)];
                    open_tot[k]  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(1, 5);
                    open_next[k] = 0;
                    open_live[k] = 1;
                end
                it = frag(open_mac[k], $urandom_range(0, 255),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : open_next[k],
                          open_tot[k], $urandom_range(0, 250));
                open_next[k]++;
                if ((open_tot[k] != 0 && open_next[k] >= open_tot[k]) || open_next[k] >= 12
                        || $urandom_range(0, 19) == 0)
                    open_live[k] = 0;
                send_item(it);
            end else begin
                it = frag(mac_pool[$urandom_range(0, 5)], $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 250));
                // unknown senders never open a slot, else it would stay busy for good
                if ($urandom_range(0, 3) == 0) begin
                    it.mac = MAC_W'({$urandom, $urandom});
                    if (it.idx == '0) it.idx = 8'd1;
                end
                send_item(it);
            end
            if (n % 250 == 249) settle();
        end
        settle();

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("fragment_reassembly_table verification clean");
        end else begin
            $display("fragment_reassembly_table verification failed");
        end
        $finish;
    end

endmodule
